FILE: design/kplc_pkg.sv
// Shared constants for the keypad code lock: register map, input kinds,
// event codes and code-compare sizing. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kplc_pkg;

    // Number of keys in a code; the entry buffer is four key bytes wide.
    localparam int CODE_LENGTH = 4;
    localparam int CNT_W       = $clog2(CODE_LENGTH + 1);

    localparam logic [31:0] CODE_MASK = (CODE_LENGTH >= 4) ? 32'hFFFF_FFFF :
        32'((64'd1 << (8 * CODE_LENGTH)) - 64'd1);

    localparam logic [7:0] KEY_CANCEL = 8'h2A;

    // Register indexes (byte address = 4 * index)
    typedef enum logic [1:0] {
        REG_PIN_CODE     = 2'd0,
        REG_MAX_WRONG    = 2'd1,
        REG_WRONG_WINDOW = 2'd2,
        REG_IDLE_TIMEOUT = 2'd3
    } reg_idx_t;

    // Input item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_KEY   = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Result events
    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_STARTED   = 4'd1;
    localparam logic [3:0] EV_REFUSED   = 4'd2;
    localparam logic [3:0] EV_KEY_TAKEN = 4'd3;
    localparam logic [3:0] EV_UNLOCKED  = 4'd4;
    localparam logic [3:0] EV_FACTORY   = 4'd5;
    localparam logic [3:0] EV_WRONG     = 4'd6;
    localparam logic [3:0] EV_DISABLED  = 4'd7;
    localparam logic [3:0] EV_CANCEL    = 4'd8;
    localparam logic [3:0] EV_TIMEOUT   = 4'd9;

endpackage

`default_nettype wire

FILE: design/keypad_pin_lock_controller_core.sv
// Keypad code lock with wrong-entry lockout: stream in, one result beat out per item.
// Depends on kplc_pkg for the register map, event codes and code sizing.
//
// Each input beat lands in an input register; once the result side can advance, its result
// is worked out by one pass of compare and update logic and loaded, together with the lock
// state, into the result register. One item is taken every clock cycle while the sink is
// ready, and its result beat is valid once the result register is loaded. While a result
// waits for the sink, the input register still takes one more beat; the input then stalls
// until the sink takes the result. The user must write registers over the APB port only
// while no item is in flight; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module keypad_pin_lock_controller_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // key_code[7:0], reset_request[8], wall_seconds[40:9]
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // event_res[3:0], keys_entered[6:4], wrong_count[14:7]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW = kplc_pkg::CNT_W;

    // configuration registers
    logic [31:0] pin_code_reg;
    logic [7:0]  max_wrong_reg;
    logic [31:0] wrong_window_reg;
    logic [31:0] idle_timeout_reg;

    // input register
    logic        in_valid_reg;
    logic [1:0]  in_kind_reg;
    logic [7:0]  in_key_reg;
    logic        in_rst_req_reg;
    logic [31:0] in_now_reg;

    // lock state
    logic          session_reg,   session_next;
    logic          reset_mode_reg, reset_mode_next;
    logic [31:0]   buffer_reg,    buffer_next;
    logic [CW-1:0] count_reg,     count_next;
    logic [7:0]    wrong_reg,     wrong_next;
    logic [31:0]   first_wrong_reg, first_wrong_next;
    logic [31:0]   idle_reg,      idle_next;

    // result register
    logic        out_valid_reg;
    logic [3:0]  ev_reg, ev_next;

    logic        advance;
    logic        cfg_write;

    // scratch for the single pass
    logic        window_clear;
    logic [7:0]  wrong_eff;
    logic [31:0] first_eff;
    logic [31:0] shifted;
    logic [7:0]  wrong_inc;
    logic [31:0] idle_inc;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (kplc_pkg::reg_idx_t'(paddr[3:2]))
            kplc_pkg::REG_PIN_CODE:     prdata = pin_code_reg;
            kplc_pkg::REG_MAX_WRONG:    prdata = {24'd0, max_wrong_reg};
            kplc_pkg::REG_WRONG_WINDOW: prdata = wrong_window_reg;
            kplc_pkg::REG_IDLE_TIMEOUT: prdata = idle_timeout_reg;
            default:                    prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        session_next     = session_reg;
        reset_mode_next  = reset_mode_reg;
        buffer_next      = buffer_reg;
        count_next       = count_reg;
        wrong_next       = wrong_reg;
        first_wrong_next = first_wrong_reg;
        idle_next        = idle_reg;
        ev_next          = kplc_pkg::EV_NONE;

        window_clear = (first_wrong_reg != 32'd0) && (in_now_reg >= first_wrong_reg) &&
                       ((in_now_reg - first_wrong_reg) > wrong_window_reg);
        wrong_eff = window_clear ? 8'd0  : wrong_reg;
        first_eff = window_clear ? 32'd0 : first_wrong_reg;
        shifted   = {buffer_reg[23:0], in_key_reg};
        wrong_inc = (wrong_reg == 8'hFF) ? wrong_reg : wrong_reg + 8'd1;
        idle_inc  = (idle_reg == 32'hFFFF_FFFF) ? idle_reg : idle_reg + 32'd1;

        case (in_kind_reg)
            kplc_pkg::KIND_START:
            begin
                // drop any running session, then decide afresh
                session_next     = 1'b0;
                buffer_next      = 32'd0;
                count_next       = '0;
                idle_next        = 32'd0;
                wrong_next       = wrong_eff;
                first_wrong_next = first_eff;
                if (first_eff == 32'd0 && wrong_eff == 8'd0 && max_wrong_reg != 8'd0)
                    ev_next = kplc_pkg::EV_STARTED;
                else if (wrong_eff >= max_wrong_reg)
                    ev_next = kplc_pkg::EV_REFUSED;
                else
                    ev_next = kplc_pkg::EV_STARTED;
                if (ev_next == kplc_pkg::EV_STARTED)
                begin
                    session_next    = 1'b1;
                    reset_mode_next = in_rst_req_reg;
                end
            end
            kplc_pkg::KIND_KEY:
            begin
                if (session_reg && in_key_reg != 8'd0)
                begin
                    idle_next = 32'd0;
                    if (in_key_reg == kplc_pkg::KEY_CANCEL)
                    begin
                        session_next = 1'b0;
                        buffer_next  = 32'd0;
                        count_next   = '0;
                        ev_next      = kplc_pkg::EV_CANCEL;
                    end
                    else if (32'(count_reg) + 32'd1 >= 32'(kplc_pkg::CODE_LENGTH))
                    begin
                        buffer_next = 32'd0;
                        count_next  = '0;
                        if ((shifted & kplc_pkg::CODE_MASK) ==
                            (pin_code_reg & kplc_pkg::CODE_MASK))
                        begin
                            ev_next = reset_mode_reg ? kplc_pkg::EV_FACTORY
                                                     : kplc_pkg::EV_UNLOCKED;
                            wrong_next       = 8'd0;
                            first_wrong_next = 32'd0;
                            session_next     = 1'b0;
                        end
                        else
                        begin
                            wrong_next = wrong_inc;
                            // stamp the first miss only
                            if (wrong_inc == 8'd1)
                                first_wrong_next = in_now_reg;
                            if (wrong_inc >= max_wrong_reg)
                            begin
                                ev_next      = kplc_pkg::EV_DISABLED;
                                session_next = 1'b0;
                            end
                            else
                                ev_next = kplc_pkg::EV_WRONG;
                        end
                    end
                    else
                    begin
                        buffer_next = shifted;
                        count_next  = count_reg + CW'(1);
                        ev_next     = kplc_pkg::EV_KEY_TAKEN;
                    end
                end
            end
            kplc_pkg::KIND_TICK:
            begin
                if (session_reg)
                begin
                    idle_next = idle_inc;
                    if (idle_inc > idle_timeout_reg)
                    begin
                        session_next = 1'b0;
                        buffer_next  = 32'd0;
                        count_next   = '0;
                        idle_next    = 32'd0;
                        ev_next      = kplc_pkg::EV_TIMEOUT;
                    end
                end
            end
            default:
            begin
                ev_next = kplc_pkg::EV_NONE;
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_code_reg     <= 32'd0;
            max_wrong_reg    <= 8'd5;
            wrong_window_reg <= 32'd1800;
            idle_timeout_reg <= 32'd10000;
        end
        else if (cfg_write)
        begin
            case (kplc_pkg::reg_idx_t'(paddr[3:2]))
                kplc_pkg::REG_PIN_CODE:     pin_code_reg     <= pwdata;
                kplc_pkg::REG_MAX_WRONG:    max_wrong_reg    <= pwdata[7:0];
                kplc_pkg::REG_WRONG_WINDOW: wrong_window_reg <= pwdata;
                kplc_pkg::REG_IDLE_TIMEOUT: idle_timeout_reg <= pwdata;
                default:                    pin_code_reg     <= pin_code_reg;
            endcase
        end
    end

    // input register: hold the beat until the result side can take it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg    <= s_tuser;
            in_key_reg     <= s_tdata[7:0];
            in_rst_req_reg <= s_tdata[8];
            in_now_reg     <= s_tdata[40:9];
        end
    end

    // lock state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            session_reg     <= 1'b0;
            reset_mode_reg  <= 1'b0;
            buffer_reg      <= 32'd0;
            count_reg       <= '0;
            wrong_reg       <= 8'd0;
            first_wrong_reg <= 32'd0;
            idle_reg        <= 32'd0;
            out_valid_reg   <= 1'b0;
            ev_reg          <= kplc_pkg::EV_NONE;
        end
        else
        begin
            if (advance)
            begin
                session_reg     <= session_next;
                reset_mode_reg  <= reset_mode_next;
                buffer_reg      <= buffer_next;
                count_reg       <= count_next;
                wrong_reg       <= wrong_next;
                first_wrong_reg <= first_wrong_next;
                idle_reg        <= idle_next;
                ev_reg          <= ev_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // keys_entered and wrong_count reflect the state left by the item in the result register
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, wrong_reg, 3'(count_reg), ev_reg};

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// Self-checking bench for keypad_pin_lock_controller_core: directed and random streams
// of start, key and tick beats, each result checked against an in-bench lock predictor.
// Depends on kplc_pkg (register indexes, kinds, event codes) and the core itself.
`timescale 1ns / 1ps

module tb_top;

    // kind value with no meaning; the core must ignore it
    localparam logic [1:0] KIND_SPARE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  key;
        logic        rreq;
        logic [31:0] wall;
    } lock_item_t;

    typedef struct packed {
        logic [3:0] ev;
        logic [2:0] keys;
        logic [7:0] wrong;
    } lock_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // key_code[7:0], reset_request[8], wall_seconds[40:9]
    logic [1:0]  s_tuser = '0;    // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // event_res[3:0], keys_entered[6:4], wrong_count[14:7]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    keypad_pin_lock_controller_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // Lock predictor state and its copy of the registers
    logic [31:0] cfg_pin = 32'd0;
    logic [7:0]  cfg_max_wrong = 8'd5;
    logic [31:0] cfg_window = 32'd1800;
    logic [31:0] cfg_idle = 32'd10000;
    logic        sess_on = 1'b0;
    logic        factory_mode = 1'b0;
    logic [31:0] entry_buf = '0;
    logic [31:0] entry_cnt = '0;
    logic [7:0]  wrong_cnt = '0;
    logic [31:0] miss_stamp = '0;
    logic [31:0] idle_ms = '0;

    lock_item_t   pending_items[$];
    lock_result_t expected_results[$];

    lock_item_t   drv_item;
    lock_item_t   seen_item;
    lock_result_t got_res;
    lock_result_t want_res;
    bit           in_taken = 1'b0;
    bit           out_taken = 1'b0;
    bit           calm = 1'b0;
    int           src_wait = 0;
    int           sink_wait = 0;
    int           mismatches = 0;
    int           phase_items = 0;
    logic [31:0]  wall_now = 32'd1000;

    function automatic void drop_session();
        sess_on = 1'b0;
        entry_buf = '0;
        entry_cnt = '0;
        idle_ms = '0;
    endfunction

    function automatic lock_result_t lock_step(input lock_item_t it);
        lock_result_t r;
        logic [31:0]  mask;
        logic [3:0]   ev;
        ev = kplc_pkg::EV_NONE;
        mask = kplc_pkg::CODE_MASK;
        case (it.kind)
            kplc_pkg::KIND_START:
            begin
                drop_session();
                // window expiry clears the count; a clock that went backwards never does
                if (miss_stamp != 0 && it.wall >= miss_stamp
                    && (it.wall - miss_stamp) > cfg_window)
                begin
                    wrong_cnt = '0;
                    miss_stamp = '0;
                end
                if (miss_stamp == 0 && wrong_cnt == 0 && cfg_max_wrong != 0)
                    ev = kplc_pkg::EV_STARTED;
                else if (wrong_cnt >= cfg_max_wrong)
                    ev = kplc_pkg::EV_REFUSED;
                else
                    ev = kplc_pkg::EV_STARTED;
                if (ev == kplc_pkg::EV_STARTED)
                begin
                    sess_on = 1'b1;
                    factory_mode = it.rreq;
                end
            end
            kplc_pkg::KIND_KEY:
            begin
                if (sess_on && it.key != 8'd0)
                begin
                    idle_ms = '0;
                    if (it.key == kplc_pkg::KEY_CANCEL)
                    begin
                        drop_session();
                        ev = kplc_pkg::EV_CANCEL;
                    end
                    else
                    begin
                        entry_buf = {entry_buf[23:0], it.key};
                        entry_cnt = entry_cnt + 32'd1;
                        ev = kplc_pkg::EV_KEY_TAKEN;
                        if (entry_cnt >= 32'(kplc_pkg::CODE_LENGTH))
                        begin
                            if ((entry_buf & mask) == (cfg_pin & mask))
                            begin
                                ev = factory_mode ? kplc_pkg::EV_FACTORY
                                                  : kplc_pkg::EV_UNLOCKED;
                                wrong_cnt = '0;
                                miss_stamp = '0;
                                drop_session();
                            end
                            else
                            begin
                                if (wrong_cnt != 8'hFF)
                                    wrong_cnt = wrong_cnt + 8'd1;
                                if (wrong_cnt == 8'd1)
                                    miss_stamp = it.wall;
                                entry_buf = '0;
                                entry_cnt = '0;
                                if (wrong_cnt >= cfg_max_wrong)
                                begin
                                    ev = kplc_pkg::EV_DISABLED;
                                    drop_session();
                                end
                                else
                                begin
                                    ev = kplc_pkg::EV_WRONG;
                                end
                            end
                        end
                    end
                end
            end
            kplc_pkg::KIND_TICK:
            begin
                if (sess_on)
                begin
                    if (idle_ms != 32'hFFFF_FFFF)
                        idle_ms = idle_ms + 32'd1;
                    if (idle_ms > cfg_idle)
                    begin
                        drop_session();
                        ev = kplc_pkg::EV_TIMEOUT;
                    end
                end
            end
            default: ev = kplc_pkg::EV_NONE;
        endcase
        r.ev = ev;
        r.keys = entry_cnt[2:0];
        r.wrong = wrong_cnt;
        return r;
    endfunction

    // Input side: hold a beat until taken, then wait the drawn gap before the next
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (src_wait > 0)
            begin
                s_tvalid <= 1'b0;
                src_wait = src_wait - 1;
            end
            else if (pending_items.size() > 0)
            begin
                drv_item = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, drv_item.wall, drv_item.rreq, drv_item.key};
                s_tuser  <= drv_item.kind;
                src_wait = calm ? 0 : $urandom_range(0, 11);
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side: stall a drawn number of cycles after each taken beat
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (out_taken)
                sink_wait = calm ? 0 : $urandom_range(0, 11);
            if (sink_wait > 0)
            begin
                m_tready <= 1'b0;
                sink_wait = sink_wait - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check results before predicting the beat taken at the same edge
    always @(posedge clk)
    begin
        in_taken = 1'b0;
        out_taken = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                out_taken = 1'b1;
                got_res.ev = m_tdata[3:0];
                got_res.keys = m_tdata[6:4];
                got_res.wrong = m_tdata[14:7];
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, actual %h", $time,
                             m_tdata);
                end
                else
                begin
                    want_res = expected_results.pop_front();
                    if (got_res.ev !== want_res.ev)
                    begin
                        mismatches++;
                        $display("%0t: event_res expected %0d actual %0d", $time,
                                 want_res.ev, got_res.ev);
                    end
                    if (got_res.keys !== want_res.keys)
                    begin
                        mismatches++;
                        $display("%0t: keys_entered expected %0d actual %0d", $time,
                                 want_res.keys, got_res.keys);
                    end
                    if (got_res.wrong !== want_res.wrong)
                    begin
                        mismatches++;
                        $display("%0t: wrong_count expected %0d actual %0d", $time,
                                 want_res.wrong, got_res.wrong);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                in_taken = 1'b1;
                seen_item.kind = s_tuser;
                seen_item.key  = s_tdata[7:0];
                seen_item.rreq = s_tdata[8];
                seen_item.wall = s_tdata[40:9];
                expected_results.push_back(lock_step(seen_item));
            end
        end
    end

    task automatic put(input logic [1:0] kind, input logic [7:0] key, input logic rreq,
                       input logic [31:0] wall);
        lock_item_t it;
        it.kind = kind;
        it.key = key;
        it.rreq = rreq;
        it.wall = wall;
        pending_items.push_back(it);
        phase_items++;
    endtask

    // Register write followed by a read back of the same register
    task automatic cfg_write(input kplc_pkg::reg_idx_t idx, input logic [31:0] val);
        logic [31:0] want;
        want = (idx == kplc_pkg::REG_MAX_WRONG) ? {24'd0, val[7:0]} : val;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite <= 1'b0;
        penable <= 1'b0;
        case (idx)
            kplc_pkg::REG_PIN_CODE:     cfg_pin = val;
            kplc_pkg::REG_MAX_WRONG:    cfg_max_wrong = val[7:0];
            kplc_pkg::REG_WRONG_WINDOW: cfg_window = val;
            default:                    cfg_idle = val;
        endcase
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            mismatches++;
            $display("%0t: read back of register %0d expected %h actual %h", $time, idx,
                     want, prdata);
        end
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] pin, input logic [7:0] mx,
                              input logic [31:0] win, input logic [31:0] idl);
        cfg_write(kplc_pkg::REG_PIN_CODE, pin);
        cfg_write(kplc_pkg::REG_MAX_WRONG, {24'd0, mx});
        cfg_write(kplc_pkg::REG_WRONG_WINDOW, win);
        cfg_write(kplc_pkg::REG_IDLE_TIMEOUT, idl);
    endtask

    // Wait for every beat to be taken and every result to arrive, then let the pipe settle
    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    function automatic logic [7:0] digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [31:0] pick_wall();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 32'd0;
        if (r == 1)
            return $urandom();
        if (r == 2)
            return wall_now - 32'($urandom_range(1, 30));
        wall_now = wall_now + 32'($urandom_range(0, 12));
        return wall_now;
    endfunction

    task automatic put_tick();
        put(kplc_pkg::KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            $urandom());
    endtask

    // One well-formed session: start, one to three code attempts, maybe an idle run
    task automatic put_session();
        int n_tries;
        int good;
        int n;
        logic [7:0] k;
        put(kplc_pkg::KIND_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
            pick_wall());
        n_tries = $urandom_range(1, 3);
        for (int a = 0; a < n_tries; a++)
        begin
            good = $urandom_range(0, 1);
            for (int i = 0; i < 4; i++)
            begin
                if ($urandom_range(0, 24) == 0)
                    put(kplc_pkg::KIND_KEY, kplc_pkg::KEY_CANCEL, 1'($urandom_range(0, 1)),
                        pick_wall());
                k = good ? cfg_pin[31 - 8 * i -: 8] : digit();
                put(kplc_pkg::KIND_KEY, k, 1'($urandom_range(0, 1)), pick_wall());
                if ($urandom_range(0, 3) == 0)
                begin
                    n = $urandom_range(1, 2);
                    repeat (n) put_tick();
                end
            end
        end
        if ($urandom_range(0, 3) == 0)
        begin
            n = (cfg_idle < 40) ? int'(cfg_idle) + 1 : $urandom_range(1, 5);
            repeat (n) put_tick();
        end
    endtask

    task automatic run_phase(input int n_items, input bit quiet);
        calm = quiet;
        phase_items = 0;
        while (phase_items < n_items)
        begin
            if ($urandom_range(0, 9) < 7)
                put_session();
            else
                put(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), $urandom());
        end
        drain();
    endtask

    function automatic logic [31:0] digit_pin();
        return {digit(), digit(), digit(), digit()};
    endfunction

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: code "1234", second miss disables, ten second window, idle after 3 ms
        set_config(32'h3132_3334, 8'd2, 32'd10, 32'd3);
        put(kplc_pkg::KIND_KEY, "1", 1'b0, 32'd50);              // key with no session
        put(kplc_pkg::KIND_TICK, 8'd0, 1'b0, 32'd50);            // tick with no session
        put(KIND_SPARE, 8'hFF, 1'b1, 32'hFFFF_FFFF);             // unused kind
        put(kplc_pkg::KIND_START, 8'd0, 1'b1, 32'd100);          // factory reset mode
        put(kplc_pkg::KIND_KEY, 8'd0, 1'b0, 32'd100);            // null key ignored
        put(kplc_pkg::KIND_KEY, "1", 1'b0, 32'd100);
        put(kplc_pkg::KIND_KEY, "2", 1'b0, 32'd100);
        put(kplc_pkg::KIND_KEY, "3", 1'b0, 32'd100);
        put(kplc_pkg::KIND_KEY, "4", 1'b0, 32'd100);
        put(kplc_pkg::KIND_START, 8'd0, 1'b0, 32'd200);
        put(kplc_pkg::KIND_KEY, "1", 1'b0, 32'd200);
        put(kplc_pkg::KIND_KEY, "2", 1'b0, 32'd200);
        put(kplc_pkg::KIND_KEY, "3", 1'b0, 32'd200);
        put(kplc_pkg::KIND_KEY, "5", 1'b0, 32'd200);             // first miss stamped at 200
        put(kplc_pkg::KIND_KEY, kplc_pkg::KEY_CANCEL, 1'b0, 32'd201);
        put(kplc_pkg::KIND_START, 8'd0, 1'b1, 32'd205);          // inside window, below limit
        repeat (4) put(kplc_pkg::KIND_KEY, "9", 1'b1, 32'd206);  // second miss disables
        put(kplc_pkg::KIND_START, 8'd0, 1'b0, 32'd190);          // clock went backwards
        put(kplc_pkg::KIND_START, 8'd0, 1'b0, 32'd211);          // window expired, count clears
        repeat (4) put(kplc_pkg::KIND_TICK, 8'd0, 1'b0, 32'd0);  // idle timeout
        calm = 1'b0;
        drain();

        set_config(digit_pin(), 8'd3, 32'd20, 32'd5);
        run_phase(150, 1'b1);
        set_config(32'hFFFF_FFFF, 8'd1, 32'd0, 32'd0);
        run_phase(150, 1'b0);
        set_config(32'd0, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(150, 1'b0);
        // zero limit refuses every start
        set_config(digit_pin(), 8'd0, 32'd5, 32'd8);
        run_phase(40, 1'b0);
        set_config(digit_pin(), 8'($urandom_range(1, 8)), 32'($urandom_range(0, 60)),
                   32'($urandom_range(1, 30)));
        run_phase(150, 1'b0);
        set_config($urandom(), 8'($urandom_range(1, 8)), 32'($urandom_range(0, 60)),
                   32'($urandom_range(1, 30)));
        run_phase(150, 1'b0);
        set_config(digit_pin(), 8'($urandom_range(1, 8)), 32'($urandom_range(0, 60)),
                   32'($urandom_range(1, 30)));
        run_phase(150, 1'b1);
        set_config(digit_pin(), 8'($urandom_range(2, 6)), 32'($urandom_range(0, 30)),
                   32'($urandom_range(0, 12)));
        run_phase(150, 1'b0);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
design/kplc_pkg.sv
design/keypad_pin_lock_controller_core.sv
tb/sv/tb_top.sv
